// ===== rtl/lmsdfe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LMS DFE package
// Shared widths, formats, register map and a helper function of the binary
// LMS decision feedback equalizer.
// ----------------------------------------------------------------------------
package lmsdfe_pkg;

  // Default tap counts
  localparam int FF_TAPS_DEF = 8;
  localparam int FB_TAPS_DEF = 4;

  // Field and storage widths
  localparam int SAMPLE_W = 16;              // Q3.12 sample and output
  localparam int COEF_W   = 18;              // Q3.14 coefficient
  localparam int MU_W     = 16;              // Q0.16 step size
  localparam int GAP_W    = 8;
  localparam int CNT_W    = 8;               // saturating sample count
  localparam int DEC_W    = 2;               // stored decision code

  // Shared multiplier: A is a coefficient, a step size or mu*e; B is a
  // sample, a decision value or the error.
  localparam int MA_W  = MU_W + SAMPLE_W + 1;
  localparam int MB_W  = SAMPLE_W;
  localparam int MP_W  = MA_W + MB_W;
  localparam int DOT_W = COEF_W + SAMPLE_W;  // exact width of one tap product

  // Fixed-point constants
  localparam int COEF_ONE  = 16384;
  localparam int COEF_MAX  = 131071;
  localparam int COEF_MIN  = -131072;
  localparam int DEC_ONE   = 4096;
  localparam int OUT_MAX   = 32767;
  localparam int OUT_MIN   = -32768;
  localparam int ACC_SHIFT = 14;
  localparam int UPD_SHIFT = 26;
  localparam logic [CNT_W-1:0] COUNT_MAX = 8'd255;

  // Reset values of the configuration registers
  localparam logic [MU_W-1:0]  MU_FF_RST     = 16'd328;
  localparam logic [MU_W-1:0]  MU_FB_RST     = 16'd328;
  localparam logic [GAP_W-1:0] REARM_GAP_RST = 8'd50;

  // Configuration port
  localparam int CFG_AW    = 4;
  localparam int CFG_DW    = 32;
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_MU_FF     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MU_FB     = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_REARM_GAP = 2'd2;

  // Stored decision codes
  localparam logic [DEC_W-1:0] DEC_NONE = 2'b00;
  localparam logic [DEC_W-1:0] DEC_POS  = 2'b01;
  localparam logic [DEC_W-1:0] DEC_NEG  = 2'b11;

  typedef struct packed {
    logic [MU_W-1:0]  mu_ff;
    logic [MU_W-1:0]  mu_fb;
    logic [GAP_W-1:0] rearm_gap;
  } cfg_t;

  // A stored decision as a Q3.12 value.
  function automatic logic signed [MB_W-1:0] dec_operand(input logic [DEC_W-1:0] d);
    logic signed [MB_W-1:0] v;
    case (d)
      DEC_POS: v = MB_W'(DEC_ONE);
      DEC_NEG: v = MB_W'(-DEC_ONE);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/lmsdfe_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LMS DFE configuration registers
// APB-style register file holding the two step sizes and the rearm gap.
// ----------------------------------------------------------------------------
module lmsdfe_cfg
  import lmsdfe_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  logic [MU_W-1:0]      mu_ff_r;
  logic [MU_W-1:0]      mu_fb_r;
  logic [GAP_W-1:0]     gap_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_AW-1:2];
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mu_ff_r <= MU_FF_RST;
      mu_fb_r <= MU_FB_RST;
      gap_r   <= REARM_GAP_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MU_FF:     mu_ff_r <= pwdata[MU_W-1:0];
        REG_MU_FB:     mu_fb_r <= pwdata[MU_W-1:0];
        REG_REARM_GAP: gap_r   <= pwdata[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MU_FF:     prdata = {{(CFG_DW-MU_W){1'b0}}, mu_ff_r};
      REG_MU_FB:     prdata = {{(CFG_DW-MU_W){1'b0}}, mu_fb_r};
      REG_REARM_GAP: prdata = {{(CFG_DW-GAP_W){1'b0}}, gap_r};
      default:       prdata = '0;
    endcase
  end

  assign cfg.mu_ff     = mu_ff_r;
  assign cfg.mu_fb     = mu_fb_r;
  assign cfg.rearm_gap = gap_r;

endmodule
`default_nettype wire

// ===== rtl/lmsdfe_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LMS DFE shared multiplier
// Signed multiplier with a registered product, shared by the filter, error
// scaling and tap update passes.
// ----------------------------------------------------------------------------
module lmsdfe_mul
  import lmsdfe_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic signed [MA_W-1:0] a,
  input  wire logic signed [MB_W-1:0] b,
  output logic signed      [MP_W-1:0] prod_r
);

  logic signed [MP_W-1:0] prod_nxt;

  assign prod_nxt = MP_W'(a) * MP_W'(b);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule
`default_nettype wire

// ===== rtl/lmsdfe_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LMS DFE core
// Tap storage, histories and the sequencer that walks all taps through the
// shared multiplier once for the output and once for the update.
// ----------------------------------------------------------------------------
module lmsdfe_core
  import lmsdfe_pkg::*;
#(
  parameter int FF_TAPS = FF_TAPS_DEF,
  parameter int FB_TAPS = FB_TAPS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire cfg_t                       cfg,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic signed [SAMPLE_W-1:0] in_sample,
  input  wire logic                       in_sync,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed      [SAMPLE_W-1:0] out_y,
  output logic                            out_dec
);

  localparam int NT    = FF_TAPS + FB_TAPS;
  localparam int TW    = $clog2(NT);
  localparam int FFW   = (FF_TAPS > 1) ? $clog2(FF_TAPS) : 1;
  localparam int FBW   = (FB_TAPS > 1) ? $clog2(FB_TAPS) : 1;
  localparam int ACC_W = DOT_W + TW + 1;
  localparam int CS_W  = MP_W - UPD_SHIFT + 1;

  localparam logic [TW-1:0] LAST_TAP = TW'(NT - 1);
  localparam logic [TW-1:0] FB_BASE  = TW'(FF_TAPS);

  localparam logic signed [ACC_W-1:0]    ACC_HALF  = ACC_W'(1 << (ACC_SHIFT - 1));
  localparam logic signed [ACC_W-1:0]    OUT_MAX_A = ACC_W'(OUT_MAX);
  localparam logic signed [ACC_W-1:0]    OUT_MIN_A = ACC_W'(OUT_MIN);
  localparam logic signed [MP_W-1:0]     UPD_HALF  = MP_W'(64'sd1 <<< (UPD_SHIFT - 1));
  localparam logic signed [CS_W-1:0]     C_MAX     = CS_W'(COEF_MAX);
  localparam logic signed [CS_W-1:0]     C_MIN     = CS_W'(COEF_MIN);
  localparam logic signed [SAMPLE_W:0]   DEC_P     = (SAMPLE_W + 1)'(DEC_ONE);
  localparam logic signed [SAMPLE_W:0]   DEC_N     = (SAMPLE_W + 1)'(-DEC_ONE);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DOT,
    S_DRAIN,
    S_ROUND,
    S_MUFF,
    S_MUFB,
    S_CAPT,
    S_UPD,
    S_UDRAIN,
    S_OUT
  } state_t;

  state_t                      state_r;
  logic [TW-1:0]               tap_r;
  logic [TW-1:0]               tap_d_r;
  logic                        acc_en_r;
  logic                        upd_en_r;
  logic                        out_valid_r;
  logic signed [SAMPLE_W-1:0]  out_y_r;
  logic                        out_dec_r;

  logic signed [SAMPLE_W-1:0]  hist_r [FF_TAPS];
  logic signed [COEF_W-1:0]    ff_r   [FF_TAPS];
  logic signed [COEF_W-1:0]    fb_r   [FB_TAPS];
  logic [DEC_W-1:0]            dh_r   [FB_TAPS];
  logic [CNT_W-1:0]            since_r;
  logic signed [ACC_W-1:0]     acc_r;
  logic signed [SAMPLE_W-1:0]  y_r;
  logic                        dec_r;
  logic signed [SAMPLE_W-1:0]  e_r;
  logic signed [MA_W-1:0]      mff_r;
  logic signed [MA_W-1:0]      mfb_r;

  logic                        accept;
  logic                        restart;
  logic                        is_fb;
  logic [FFW-1:0]              ff_idx;
  logic [FBW-1:0]              fb_idx;
  logic signed [COEF_W-1:0]    coef_sel;
  logic signed [MB_W-1:0]      tap_b;
  logic signed [MA_W-1:0]      mul_a;
  logic signed [MB_W-1:0]      mul_b;
  logic signed [MP_W-1:0]      prod;

  logic                        wb_fb;
  logic [FFW-1:0]              wb_ff_idx;
  logic [FBW-1:0]              wb_fb_idx;
  logic signed [ACC_W-1:0]     dot_term;
  logic signed [ACC_W-1:0]     acc_rnd;
  logic signed [SAMPLE_W-1:0]  y_sat;
  logic                        y_dec;
  logic signed [SAMPLE_W:0]    y_ext;
  logic signed [SAMPLE_W:0]    err_w;
  logic signed [MP_W-1:0]      upd_sum;
  logic signed [CS_W-2:0]      delta;
  logic signed [COEF_W-1:0]    coef_old;
  logic signed [CS_W-1:0]      coef_ext;
  logic signed [CS_W-1:0]      delta_ext;
  logic signed [CS_W-1:0]      csum;
  logic signed [COEF_W-1:0]    coef_new;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid & in_ready;
  assign restart   = in_sync && (since_r > cfg.rearm_gap);
  assign out_valid = out_valid_r;
  assign out_y     = out_y_r;
  assign out_dec   = out_dec_r;

  // Tap being issued to the multiplier: feed-forward taps first, then feedback.
  assign is_fb    = (tap_r >= FB_BASE);
  assign ff_idx   = FFW'(tap_r);
  assign fb_idx   = FBW'(tap_r - FB_BASE);
  assign coef_sel = is_fb ? fb_r[fb_idx] : ff_r[ff_idx];
  assign tap_b    = is_fb ? dec_operand(dh_r[fb_idx]) : hist_r[ff_idx];

  always_comb begin
    case (state_r)
      S_DOT:   mul_a = {{(MA_W-COEF_W){coef_sel[COEF_W-1]}}, coef_sel};
      S_UPD:   mul_a = is_fb ? mfb_r : mff_r;
      S_MUFF:  mul_a = {{(MA_W-MU_W){1'b0}}, cfg.mu_ff};
      S_MUFB:  mul_a = {{(MA_W-MU_W){1'b0}}, cfg.mu_fb};
      default: mul_a = '0;
    endcase
  end

  always_comb begin
    case (state_r)
      S_DOT, S_UPD:   mul_b = tap_b;
      S_MUFF, S_MUFB: mul_b = e_r;
      default:        mul_b = '0;
    endcase
  end

  lmsdfe_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod)
  );

  // Tap whose product comes out of the multiplier this cycle.
  assign wb_fb     = (tap_d_r >= FB_BASE);
  assign wb_ff_idx = FFW'(tap_d_r);
  assign wb_fb_idx = FBW'(tap_d_r - FB_BASE);

  // Output: exact sum, round half up, saturate; zero slices to +1.
  assign dot_term = {{(ACC_W-DOT_W){prod[DOT_W-1]}}, prod[DOT_W-1:0]};
  assign acc_rnd  = (acc_r + ACC_HALF) >>> ACC_SHIFT;
  assign y_sat    = (acc_rnd > OUT_MAX_A) ? SAMPLE_W'(OUT_MAX) :
                    (acc_rnd < OUT_MIN_A) ? SAMPLE_W'(OUT_MIN) :
                    acc_rnd[SAMPLE_W-1:0];
  assign y_dec    = ~y_sat[SAMPLE_W-1];
  assign y_ext    = {y_sat[SAMPLE_W-1], y_sat};
  assign err_w    = y_dec ? (DEC_P - y_ext) : (DEC_N - y_ext);

  // Tap update: the rounded step is subtracted for feedback taps so that
  // rounding sees the same sign as the unnegated product.
  assign upd_sum   = prod + UPD_HALF;
  assign delta     = upd_sum[MP_W-1:UPD_SHIFT];
  assign coef_old  = wb_fb ? fb_r[wb_fb_idx] : ff_r[wb_ff_idx];
  assign coef_ext  = {{(CS_W-COEF_W){coef_old[COEF_W-1]}}, coef_old};
  assign delta_ext = {delta[CS_W-2], delta};
  assign csum      = wb_fb ? (coef_ext - delta_ext) : (coef_ext + delta_ext);
  assign coef_new  = (csum > C_MAX) ? COEF_W'(COEF_MAX) :
                     (csum < C_MIN) ? COEF_W'(COEF_MIN) :
                     csum[COEF_W-1:0];

  // Sequencer and output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tap_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // In S_OUT the output register is either reloaded or keeps its word.
      if (out_ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_DOT;
            tap_r   <= '0;
          end
        end
        S_DOT: begin
          if (tap_r == LAST_TAP) begin
            state_r <= S_DRAIN;
            tap_r   <= '0;
          end else begin
            tap_r <= tap_r + 1'b1;
          end
        end
        S_DRAIN: state_r <= S_ROUND;
        S_ROUND: state_r <= S_MUFF;
        S_MUFF:  state_r <= S_MUFB;
        S_MUFB:  state_r <= S_CAPT;
        S_CAPT:  state_r <= S_UPD;
        S_UPD: begin
          if (tap_r == LAST_TAP) begin
            state_r <= S_UDRAIN;
            tap_r   <= '0;
          end else begin
            tap_r <= tap_r + 1'b1;
          end
        end
        S_UDRAIN: state_r <= S_OUT;
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_y_r     <= y_r;
            out_dec_r   <= dec_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Taps, histories and arithmetic registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FF_TAPS; i++) begin
        hist_r[i] <= '0;
        ff_r[i]   <= (i == FF_TAPS / 2) ? COEF_W'(COEF_ONE) : '0;
      end
      for (int i = 0; i < FB_TAPS; i++) begin
        fb_r[i] <= '0;
        dh_r[i] <= DEC_NONE;
      end
      since_r  <= '0;
      acc_r    <= '0;
      acc_en_r <= 1'b0;
      upd_en_r <= 1'b0;
      tap_d_r  <= '0;
    end else begin
      acc_en_r <= (state_r == S_DOT);
      upd_en_r <= (state_r == S_UPD);
      tap_d_r  <= tap_r;

      if (accept) begin
        for (int i = FF_TAPS - 1; i > 0; i--) begin
          hist_r[i] <= restart ? '0 : hist_r[i-1];
        end
        hist_r[0] <= in_sample;
        if (restart) begin
          for (int i = 0; i < FF_TAPS; i++) begin
            ff_r[i] <= (i == FF_TAPS / 2) ? COEF_W'(COEF_ONE) : '0;
          end
          for (int i = 0; i < FB_TAPS; i++) begin
            fb_r[i] <= '0;
            dh_r[i] <= DEC_NONE;
          end
          since_r <= CNT_W'(1);
        end else if (since_r != COUNT_MAX) begin
          since_r <= since_r + 1'b1;
        end
        acc_r <= '0;
      end

      if (acc_en_r) begin
        acc_r <= wb_fb ? (acc_r - dot_term) : (acc_r + dot_term);
      end

      if (state_r == S_ROUND) begin
        y_r   <= y_sat;
        dec_r <= y_dec;
        e_r   <= err_w[SAMPLE_W-1:0];
      end

      if (state_r == S_MUFB) begin
        mff_r <= prod[MA_W-1:0];
      end
      if (state_r == S_CAPT) begin
        mfb_r <= prod[MA_W-1:0];
      end

      if (upd_en_r) begin
        if (wb_fb) begin
          fb_r[wb_fb_idx] <= coef_new;
        end else begin
          ff_r[wb_ff_idx] <= coef_new;
        end
      end

      if (state_r == S_UDRAIN) begin
        for (int i = FB_TAPS - 1; i > 0; i--) begin
          dh_r[i] <= dh_r[i-1];
        end
        dh_r[0] <= dec_r ? DEC_POS : DEC_NEG;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lms_decision_feedback_equalizer_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Words are handled one at a time: in_tready is low while a word is in work,
// and a new input word is accepted only after the result of the last one has
// been loaded into the output register, which waits while out_tready holds off
// the word still in it. The single shared multiplier walks every tap once for
// the output and once for the coefficient update.
// Synchronous active-low reset restores the configuration registers and the
// center-spike taps and clears the histories; no clearing pass is needed.
// ----------------------------------------------------------------------------
// LMS decision feedback equalizer, top level
// Binary LMS DFE with streaming input and output words and an APB-style
// configuration port.
// ----------------------------------------------------------------------------
module lms_decision_feedback_equalizer_top
  import lmsdfe_pkg::*;
#(
  parameter int FF_TAPS = FF_TAPS_DEF,
  parameter int FB_TAPS = FB_TAPS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [15:0]       in_tdata,      // [15:0] sample_in
  input  wire logic              in_tuser,      // [0] sync_flag
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic      [15:0]       out_tdata,     // [15:0] equalized_out
  output logic                   out_tuser,     // [0] decision_bit
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output logic      [CFG_DW-1:0] cfg_prdata,
  output logic                   cfg_pready
);

  cfg_t                       cfg;
  logic signed [SAMPLE_W-1:0] eq_y;

  lmsdfe_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  lmsdfe_core #(
    .FF_TAPS (FF_TAPS),
    .FB_TAPS (FB_TAPS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_sample (in_tdata),
    .in_sync   (in_tuser),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_y     (eq_y),
    .out_dec   (out_tuser)
  );

  assign out_tdata = eq_y;

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LMS decision feedback equalizer testbench
// Streams directed and random samples through the equalizer under several
// step-size and rearm settings, predicts every output word with a bit-exact
// model kept in step with each accepted input word, and compares the
// equalized value and the decision of each output word in order.
// ----------------------------------------------------------------------------
module tb;
  import lmsdfe_pkg::*;

  localparam int FF_N         = FF_TAPS_DEF;
  localparam int FB_N         = FB_TAPS_DEF;
  localparam int LATENCY      = 2 * (FF_N + FB_N) + 8;
  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 400;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic [SAMPLE_W-1:0] eq;
    logic                dec;
  } eq_word_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [15:0]         in_tdata = '0;     // [15:0] sample_in
  logic                in_tuser = 1'b0;   // [0] sync_flag
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [15:0]         out_tdata;         // [15:0] equalized_out
  logic                out_tuser;         // [0] decision_bit
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]   cfg_paddr = '0;
  logic [CFG_DW-1:0]   cfg_pwdata = '0;
  logic [CFG_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  // Equalizer state as the model sees it. Decisions are kept as -1, 0 or +1.
  longint   ff_tap [FF_N];
  longint   fb_tap [FB_N];
  longint   smp_hist [FF_N];
  int       dec_hist [FB_N];
  int       since_rst;
  longint   mu_ff_q;
  longint   mu_fb_q;
  int       gap_q;

  eq_word_t expected_q[$];
  eq_word_t head;
  int       mismatches = 0;
  int       words_seen = 0;
  int       cycles = 0;
  int       rx_hold = 0;
  bit       in_idle_on = 1'b1;
  bit       out_idle_on = 1'b1;
  int       prev_sym = 0;

  lms_decision_feedback_equalizer_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint round_floor(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  task automatic restart_model();
    for (int i = 0; i < FF_N; i++) begin
      ff_tap[i] = 0;
      smp_hist[i] = 0;
    end
    ff_tap[FF_N / 2] = COEF_ONE;
    for (int i = 0; i < FB_N; i++) begin
      fb_tap[i] = 0;
      dec_hist[i] = 0;
    end
    since_rst = 0;
  endtask

  // Advances the model by one sample and queues the output word it predicts.
  task automatic predict_word(input logic [15:0] smp, input logic sync);
    longint   acc;
    longint   y;
    longint   err;
    longint   p;
    int       dec;
    eq_word_t w;
    if (sync && since_rst > gap_q) restart_model();
    if (since_rst < COUNT_MAX) since_rst++;
    for (int i = FF_N - 1; i > 0; i--) smp_hist[i] = smp_hist[i - 1];
    smp_hist[0] = longint'($signed(smp));
    acc = 0;
    for (int i = 0; i < FF_N; i++) acc += smp_hist[i] * ff_tap[i];
    for (int i = 0; i < FB_N; i++) acc -= longint'(dec_hist[i]) * DEC_ONE * fb_tap[i];
    y = clip(round_floor(acc, ACC_SHIFT), OUT_MIN, OUT_MAX);
    dec = (y >= 0) ? 1 : -1;
    err = longint'(dec) * DEC_ONE - y;
    for (int i = 0; i < FF_N; i++) begin
      p = mu_ff_q * err * smp_hist[i];
      ff_tap[i] = clip(ff_tap[i] + round_floor(p, UPD_SHIFT), COEF_MIN, COEF_MAX);
    end
    for (int i = 0; i < FB_N; i++) begin
      p = mu_fb_q * err * (longint'(dec_hist[i]) * DEC_ONE);
      fb_tap[i] = clip(fb_tap[i] - round_floor(p, UPD_SHIFT), COEF_MIN, COEF_MAX);
    end
    for (int i = FB_N - 1; i > 0; i--) dec_hist[i] = dec_hist[i - 1];
    dec_hist[0] = dec;
    w.eq = y[SAMPLE_W-1:0];
    w.dec = (dec > 0);
    expected_q.push_back(w);
  endtask

  // Valid stays high between words when no gap is drawn.
  task automatic send_word(input logic [15:0] smp, input logic sync);
    int gap;
    gap = in_idle_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= smp;
    in_tuser <= sync;
    do @(posedge clk); while (!in_tready);
    predict_word(smp, sync);
  endtask

  // Binary symbols through a short channel with one echo, plus some noise.
  function automatic logic [15:0] channel_sample();
    int sym;
    int noise;
    int v;
    sym = ($urandom_range(0, 1) != 0) ? DEC_ONE : -DEC_ONE;
    noise = int'($urandom_range(0, 1023)) - 512;
    v = sym + (prev_sym * 3) / 8 + noise;
    prev_sym = sym;
    return 16'(v);
  endfunction

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_MU_FF:     mu_ff_q = longint'(val[MU_W-1:0]);
      REG_MU_FB:     mu_fb_q = longint'(val[MU_W-1:0]);
      REG_REARM_GAP: gap_q = int'(val[GAP_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic apply_settings(input int mf, input int mb, input int g);
    drain_results();
    write_reg(REG_MU_FF, mf);
    write_reg(REG_MU_FB, mb);
    write_reg(REG_REARM_GAP, g);
  endtask

  task automatic test_directed_extremes();
    // The center tap alone passes the sample four words late, so the first
    // outputs are exactly zero and must slice to +1.
    send_word(16'h0000, 1'b0);
    send_word(16'h7FFF, 1'b0);
    send_word(16'h8000, 1'b0);
    send_word(16'h0001, 1'b1);   // sync arriving too soon after reset
    send_word(16'hFFFF, 1'b0);
    send_word(16'h5555, 1'b0);
    send_word(16'hAAAA, 1'b0);
    send_word(16'h1000, 1'b0);
    send_word(16'hF000, 1'b1);
    send_word(16'h7FFF, 1'b0);
    send_word(16'h7FFF, 1'b0);
    send_word(16'h8000, 1'b0);
    send_word(16'h8000, 1'b0);
    send_word(16'h0000, 1'b0);
    send_word(16'h0000, 1'b0);
    send_word(16'h0000, 1'b0);
  endtask

  task automatic test_register_writes();
    // A write past the last register must leave every setting alone.
    drain_results();
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    for (int i = 0; i < 6; i++) send_word(channel_sample(), 1'b0);
    // Full step sizes drive the taps and the output into saturation; a zero
    // gap lets every sync restart.
    apply_settings(65535, 65535, 0);
    for (int i = 0; i < 20; i++) send_word(16'($urandom), $urandom_range(0, 5) == 0);
  endtask

  task automatic test_sync_rearm();
    apply_settings(328, 328, 10);
    for (int r = 0; r < 3; r++) begin
      for (int i = 0; i < 8 + r; i++) send_word(channel_sample(), 1'b0);
      for (int i = 0; i < 4; i++) send_word(channel_sample(), 1'b1);
    end
    // With the largest gap the saturated count never exceeds it.
    apply_settings(1000, 500, 255);
    for (int i = 0; i < 300; i++) send_word(channel_sample(), $urandom_range(0, 7) == 0);
    apply_settings(328, 328, 1);
    for (int i = 0; i < 8; i++) send_word(channel_sample(), 1'b1);
  endtask

  task automatic test_random_settings();
    int mf;
    int mb;
    int g;
    int burst;
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin
          mf = int'(MU_FF_RST);
          mb = int'(MU_FB_RST);
          g = int'(REARM_GAP_RST);
        end
        1: begin mf = 0; mb = 0; g = 255; end
        2: begin mf = 65535; mb = 65535; g = 0; end
        3: begin mf = 1; mb = 65535; g = 128; end
        4: begin mf = 65535; mb = 1; g = 7; end
        default: begin
          mf = $urandom_range(0, 4000);
          mb = $urandom_range(0, 65535);
          g = $urandom_range(0, 255);
        end
      endcase
      apply_settings(mf, mb, g);
      in_idle_on = (ph == 0) ? 1'b0 : ((ph < 3) ? 1'b1 : 1'($urandom_range(0, 1)));
      out_idle_on = (ph == 0) ? 1'b0 : ((ph < 3) ? 1'b1 : 1'($urandom_range(0, 1)));
      burst = 0;
      for (int i = 0; i < 150; i++) begin
        if (burst == 0 && $urandom_range(0, 40) == 0) burst = $urandom_range(1, 4);
        send_word(($urandom_range(0, 4) == 0) ? 16'($urandom) : channel_sample(),
                  (burst > 0) || ($urandom_range(0, 19) == 0));
        if (burst > 0) burst--;
      end
    end
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
  endtask

  task automatic test_backpressure();
    apply_settings(2000, 2000, 30);
    // The receiver stalls for a long stretch while words keep coming, so
    // the equalizer fills up and holds off its input.
    rx_hold = HOLD_CYCLES;
    for (int i = 0; i < 30; i++) send_word(channel_sample(), i == 20);
    drain_results();
    for (int i = 0; i < 10; i++) send_word(16'($urandom), 1'b0);
  endtask

  // Receiver: draws a stall before each word, or takes a long hold once.
  initial begin
    int stall;
    bit hold_taken;
    hold_taken = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (rx_hold > 0 && !hold_taken) begin
        stall = rx_hold;
        hold_taken = 1'b1;
      end else begin
        stall = out_idle_on ? $urandom_range(0, 8) : 0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      words_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("output word %0d with none expected: eq=%0d dec=%b",
                   words_seen, $signed(out_tdata), out_tuser);
      end else begin
        head = expected_q.pop_front();
        if (out_tdata !== head.eq || out_tuser !== head.dec) begin
          mismatches++;
          if (mismatches <= 10)
            $display("output word %0d: expected eq=%0d dec=%b, got eq=%0d dec=%b",
                     words_seen, $signed(head.eq), head.dec, $signed(out_tdata), out_tuser);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    mu_ff_q = longint'(MU_FF_RST);
    mu_fb_q = longint'(MU_FB_RST);
    gap_q = int'(REARM_GAP_RST);
    restart_model();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_extremes();
    test_register_writes();
    test_sync_rearm();
    test_random_settings();
    test_backpressure();
    drain_results();
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lmsdfe_pkg.sv
rtl/lmsdfe_cfg.sv
rtl/lmsdfe_mul.sv
rtl/lmsdfe_core.sv
rtl/lms_decision_feedback_equalizer_top.sv
tb/tb.sv
